// ===== src/bols_pkg.sv =====
package bols_pkg;

    localparam int VAL_W       = 32;
    localparam int CNT_W       = 9;
    localparam int IDX_W       = 9;
    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);

    localparam logic signed [VAL_W-1:0] NEG_ONE = -32'sd1;

    typedef enum logic [2:0] {
        MODE_ADD_FRONT  = 3'd0,
        MODE_ADD_BACK   = 3'd1,
        MODE_ADD_INDEX  = 3'd2,
        MODE_REM_FRONT  = 3'd3,
        MODE_REM_BACK   = 3'd4,
        MODE_REM_INDEX  = 3'd5,
        MODE_CONTAINS   = 3'd6,
        MODE_READ_INDEX = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INS,
        OP_REM,
        OP_FIND,
        OP_READ
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_FINAL
    } t_state;

    typedef struct packed {
        t_mode                   mode;
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        index;
    } t_in_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        t_status                 status;
        logic                    found;
        logic [CNT_W-1:0]        count;
    } t_out_rsp;

    typedef struct packed {
        t_op                     op;
        t_status                 status;
        logic [CNT_W-1:0]        pos;
        logic [CNT_W-1:0]        cnt;
        logic [CNT_W-1:0]        cnt_after;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

endpackage

// ===== src/bols_ram.sv =====
module bols_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                   i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                   o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bols_front.sv =====
module bols_front #(
    parameter int CAPACITY = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  bols_pkg::t_in_req i_in_data,
    output logic             o_in_stall,
    input  logic             i_q_full,
    output logic             o_push,
    output bols_pkg::t_cmd   o_cmd
);

    logic [bols_pkg::CNT_W-1:0] r_count;
    logic [bols_pkg::CNT_W-1:0] n_count;
    logic                       w_full;
    logic                       w_empty;
    bols_pkg::t_cmd             w_cmd;

    assign w_full     = (r_count == bols_pkg::CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign o_cmd      = w_cmd;

    always_comb begin
        w_cmd           = '0;
        w_cmd.op        = bols_pkg::OP_NONE;
        w_cmd.status    = bols_pkg::ST_RANGE;
        w_cmd.pos       = i_in_data.index;
        w_cmd.cnt       = r_count;
        w_cmd.cnt_after = r_count;
        w_cmd.value     = i_in_data.value;
        case (i_in_data.mode)
            bols_pkg::MODE_ADD_FRONT: begin
                w_cmd.pos = '0;
                if (w_full) begin
                    w_cmd.status = bols_pkg::ST_FULL;
                end else begin
                    w_cmd.op     = bols_pkg::OP_INS;
                    w_cmd.status = bols_pkg::ST_OK;
                end
            end
            bols_pkg::MODE_ADD_BACK: begin
                w_cmd.pos = r_count;
                if (w_full) begin
                    w_cmd.status = bols_pkg::ST_FULL;
                end else begin
                    w_cmd.op     = bols_pkg::OP_INS;
                    w_cmd.status = bols_pkg::ST_OK;
                end
            end
            bols_pkg::MODE_ADD_INDEX: begin
                if (i_in_data.index > r_count) begin
                    w_cmd.status = bols_pkg::ST_RANGE;
                end else if (w_full) begin
                    w_cmd.status = bols_pkg::ST_FULL;
                end else begin
                    w_cmd.op     = bols_pkg::OP_INS;
                    w_cmd.status = bols_pkg::ST_OK;
                end
            end
            bols_pkg::MODE_REM_FRONT: begin
                w_cmd.pos = '0;
                if (!w_empty) begin
                    w_cmd.op     = bols_pkg::OP_REM;
                    w_cmd.status = bols_pkg::ST_OK;
                end
            end
            bols_pkg::MODE_REM_BACK: begin
                w_cmd.pos = r_count - bols_pkg::CNT_W'(1);
                if (!w_empty) begin
                    w_cmd.op     = bols_pkg::OP_REM;
                    w_cmd.status = bols_pkg::ST_OK;
                end
            end
            bols_pkg::MODE_REM_INDEX: begin
                if (i_in_data.index < r_count) begin
                    w_cmd.op     = bols_pkg::OP_REM;
                    w_cmd.status = bols_pkg::ST_OK;
                end
            end
            bols_pkg::MODE_CONTAINS: begin
                w_cmd.op     = bols_pkg::OP_FIND;
                w_cmd.status = bols_pkg::ST_OK;
            end
            bols_pkg::MODE_READ_INDEX: begin
                if (i_in_data.index < r_count) begin
                    w_cmd.op     = bols_pkg::OP_READ;
                    w_cmd.status = bols_pkg::ST_OK;
                end
            end
            default: begin
                w_cmd.op = bols_pkg::OP_NONE;
            end
        endcase
        if (w_cmd.op == bols_pkg::OP_INS) begin
            w_cmd.cnt_after = r_count + bols_pkg::CNT_W'(1);
        end else if (w_cmd.op == bols_pkg::OP_REM) begin
            w_cmd.cnt_after = r_count - bols_pkg::CNT_W'(1);
        end
    end

    always_comb begin
        n_count = r_count;
        if (o_push) begin
            n_count = w_cmd.cnt_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bols_pkg::CNT_W'(CAPACITY))
        else $error("list count above capacity");
`endif

endmodule

// ===== src/bols_queue.sv =====
module bols_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bols_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output bols_pkg::t_cmd o_head
);

    bols_pkg::t_cmd                r_slot [bols_pkg::QUEUE_DEPTH];
    logic [bols_pkg::QP_W-1:0]     r_wr;
    logic [bols_pkg::QP_W-1:0]     r_rd;
    logic [bols_pkg::QP_W:0]       r_cnt;
    logic [bols_pkg::QP_W-1:0]     n_wr;
    logic [bols_pkg::QP_W-1:0]     n_rd;
    logic [bols_pkg::QP_W:0]       n_cnt;

    assign o_full  = (r_cnt == (bols_pkg::QP_W+1)'(bols_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_slot[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = r_wr + bols_pkg::QP_W'(1);
        end
        if (i_pop) begin
            n_rd = r_rd + bols_pkg::QP_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (bols_pkg::QP_W+1)'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - (bols_pkg::QP_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== src/bols_back.sv =====
module bols_back #(
    parameter int CAPACITY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  bols_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bols_pkg::t_out_rsp o_out_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    bols_pkg::t_state                  r_state;
    bols_pkg::t_state                  n_state;
    bols_pkg::t_cmd                    r_cmd;
    bols_pkg::t_cmd                    n_cmd;
    logic [AW-1:0]                     r_ptr;
    logic [AW-1:0]                     n_ptr;
    logic [AW-1:0]                     r_end;
    logic [AW-1:0]                     n_end;
    logic                              r_rv;
    logic                              n_rv;
    logic [AW-1:0]                     r_rq;
    logic [AW-1:0]                     n_rq;
    logic signed [bols_pkg::VAL_W-1:0] r_res;
    logic signed [bols_pkg::VAL_W-1:0] n_res;
    logic                              r_found;
    logic                              n_found;
    logic                              r_out_valid;
    logic                              n_out_valid;
    bols_pkg::t_out_rsp                r_out;
    bols_pkg::t_out_rsp                n_out;

    logic                              w_pop;
    logic [bols_pkg::CNT_W-1:0]        w_cnt_m1;
    logic [AW-1:0]                     w_pos;
    logic [AW-1:0]                     w_in_pos;
    logic [AW-1:0]                     w_in_last;
    logic                              w_wr_ins;
    logic                              w_wr_rem;
    logic                              w_we;
    logic [AW-1:0]                     w_waddr;
    logic [bols_pkg::VAL_W-1:0]        w_wdata;
    logic [bols_pkg::VAL_W-1:0]        w_rdata;

    bols_ram #(
        .WIDTH (bols_pkg::VAL_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_ptr),
        .o_rdata (w_rdata)
    );

    assign w_cnt_m1  = i_cmd.cnt - bols_pkg::CNT_W'(1);
    assign w_in_last = w_cnt_m1[AW-1:0];
    assign w_in_pos  = i_cmd.pos[AW-1:0];
    assign w_pos     = r_cmd.pos[AW-1:0];
    assign w_pop     = (r_state == bols_pkg::S_IDLE) && i_cmd_valid && !r_out_valid;
    assign o_cmd_pop = w_pop;

    assign w_wr_ins = r_rv && (r_cmd.op == bols_pkg::OP_INS);
    assign w_wr_rem = r_rv && (r_cmd.op == bols_pkg::OP_REM) && (r_rq != w_pos);
    assign w_we     = w_wr_ins || w_wr_rem || (r_state == bols_pkg::S_FINAL);

    always_comb begin
        if (r_state == bols_pkg::S_FINAL) begin
            w_waddr = w_pos;
            w_wdata = r_cmd.value;
        end else if (w_wr_ins) begin
            w_waddr = r_rq + AW'(1);
            w_wdata = w_rdata;
        end else begin
            w_waddr = r_rq - AW'(1);
            w_wdata = w_rdata;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_ptr       = r_ptr;
        n_end       = r_end;
        n_rv        = 1'b0;
        n_rq        = r_rq;
        n_res       = r_res;
        n_found     = r_found;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (r_rv) begin
            if ((r_cmd.op == bols_pkg::OP_READ) ||
                ((r_cmd.op == bols_pkg::OP_REM) && (r_rq == w_pos))) begin
                n_res = w_rdata;
            end
            if ((r_cmd.op == bols_pkg::OP_FIND) && (w_rdata == r_cmd.value)) begin
                n_found = 1'b1;
            end
        end

        case (r_state)
            bols_pkg::S_IDLE: begin
                if (w_pop) begin
                    n_cmd   = i_cmd;
                    n_found = 1'b0;
                    n_res   = i_cmd.value;
                    case (i_cmd.op)
                        bols_pkg::OP_INS: begin
                            if (i_cmd.cnt > i_cmd.pos) begin
                                n_ptr   = w_in_last;
                                n_end   = w_in_pos;
                                n_state = bols_pkg::S_SWEEP;
                            end else begin
                                n_state = bols_pkg::S_FINAL;
                            end
                        end
                        bols_pkg::OP_REM: begin
                            n_ptr   = w_in_pos;
                            n_end   = w_in_last;
                            n_state = bols_pkg::S_SWEEP;
                        end
                        bols_pkg::OP_READ: begin
                            n_ptr   = w_in_pos;
                            n_end   = w_in_pos;
                            n_state = bols_pkg::S_SWEEP;
                        end
                        bols_pkg::OP_FIND: begin
                            if (i_cmd.cnt != '0) begin
                                n_ptr   = '0;
                                n_end   = w_in_last;
                                n_state = bols_pkg::S_SWEEP;
                            end else begin
                                n_out_valid        = 1'b1;
                                n_out.result_value = i_cmd.value;
                                n_out.status       = bols_pkg::ST_OK;
                                n_out.found        = 1'b0;
                                n_out.count        = i_cmd.cnt_after;
                            end
                        end
                        default: begin
                            n_out_valid        = 1'b1;
                            n_out.result_value = bols_pkg::NEG_ONE;
                            n_out.status       = i_cmd.status;
                            n_out.found        = 1'b0;
                            n_out.count        = i_cmd.cnt_after;
                        end
                    endcase
                end
            end
            bols_pkg::S_SWEEP: begin
                n_rv = 1'b1;
                n_rq = r_ptr;
                if (r_ptr == r_end) begin
                    n_state = bols_pkg::S_DRAIN;
                end else if (r_cmd.op == bols_pkg::OP_INS) begin
                    n_ptr = r_ptr - AW'(1);
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            bols_pkg::S_DRAIN: begin
                if (r_cmd.op == bols_pkg::OP_INS) begin
                    n_state = bols_pkg::S_FINAL;
                end else begin
                    n_state            = bols_pkg::S_IDLE;
                    n_out_valid        = 1'b1;
                    n_out.result_value = n_res;
                    n_out.status       = bols_pkg::ST_OK;
                    n_out.found        = n_found;
                    n_out.count        = r_cmd.cnt_after;
                end
            end
            bols_pkg::S_FINAL: begin
                n_state            = bols_pkg::S_IDLE;
                n_out_valid        = 1'b1;
                n_out.result_value = r_cmd.value;
                n_out.status       = bols_pkg::ST_OK;
                n_out.found        = 1'b0;
                n_out.count        = r_cmd.cnt_after;
            end
            default: begin
                n_state = bols_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_ptr   <= n_ptr;
        r_end   <= n_end;
        r_rq    <= n_rq;
        r_res   <= n_res;
        r_found <= n_found;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bols_pkg::S_IDLE;
            r_rv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rv        <= n_rv;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != bols_pkg::S_IDLE) |-> !r_out_valid)
        else $error("result pending while a request is being carried out");
    a_drain_has_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bols_pkg::S_DRAIN) |-> r_rv)
        else $error("drain without an outstanding read");
    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_ins |-> (32'(r_rq) < CAPACITY - 1))
        else $error("insert shift beyond last entry");
`endif

endmodule

// ===== src/bounded_ordered_list_store_top.sv =====
// Channel | Direction | Handshake                       | Payload
// in      | input     | i_in_valid / o_in_stall         | i_in_data  (bols_pkg::t_in_req)
// out     | output    | o_out_valid / i_out_stall       | o_out_data (bols_pkg::t_out_rsp)
//
// Refused requests are answered in the back end with no RAM access; insert at p moves the
// entries from p on up by one and then writes the value (an append only writes it), remove
// at p reads the entry at p and moves the later ones down, contains reads each entry (none
// on an empty list) and read reads the entry at p. The RAM has one read and one write port.
// Two requests queue ahead of the back end, which takes the next one once the result is gone.
// Reset clears the count and control state at once; the element RAM is not cleared.
module bounded_ordered_list_store_top #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  bols_pkg::t_in_req  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bols_pkg::t_out_rsp o_out_data
);

    logic           w_push;
    logic           w_q_full;
    logic           w_q_valid;
    logic           w_pop;
    bols_pkg::t_cmd w_cmd_in;
    bols_pkg::t_cmd w_cmd_head;

    bols_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    bols_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_head  (w_cmd_head)
    );

    bols_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_cmd_head),
        .o_cmd_pop   (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
